FILE: rtl/lms_pkg.sv
// Shared types and command codes for the LPT makespan scheduler.
// Used by lms_ctrl, lms_datapath and lpt_makespan_scheduler; no dependencies.
package lms_pkg;

  localparam int JOB_W  = 16;
  localparam int MS_W   = 22;
  localparam int CFG_W  = 4;
  localparam int DATA_W = 24;

  localparam logic [MS_W-1:0]  MS_MAX      = 22'h3FFFFF;
  localparam logic [CFG_W-1:0] CFG_RST_VAL = 4'd8;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_STORE      = 5'd1;
  localparam op_t OP_SORT_RDI   = 5'd2;
  localparam op_t OP_SORT_LDV   = 5'd3;
  localparam op_t OP_SORT_RDJ   = 5'd4;
  localparam op_t OP_SORT_SHIFT = 5'd5;
  localparam op_t OP_SORT_FIN   = 5'd6;
  localparam op_t OP_CLR_START  = 5'd7;
  localparam op_t OP_CLR_STEP   = 5'd8;
  localparam op_t OP_A_RDJOB    = 5'd9;
  localparam op_t OP_A_LDV      = 5'd10;
  localparam op_t OP_A_RDL      = 5'd11;
  localparam op_t OP_A_CMP      = 5'd12;
  localparam op_t OP_A_ADD      = 5'd13;
  localparam op_t OP_M_START    = 5'd14;
  localparam op_t OP_M_RDL      = 5'd15;
  localparam op_t OP_M_CMP      = 5'd16;
  localparam op_t OP_OUT        = 5'd17;

  typedef struct packed {
    logic i_ge_n;
    logic j_zero;
    logic sort_lt;
    logic k_eq_m;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/lms_datapath.sv
// Datapath of the LPT makespan scheduler: job store, machine load memory,
// loop counters, compare logic and the output register. Depends on lms_pkg.
module lms_datapath #(
  parameter int MAX_JOBS     = 64,
  parameter int MAX_MACHINES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lms_pkg::op_t             op,
  input  logic [lms_pkg::JOB_W-1:0] job_in,
  input  logic                     cfg_wr_en,
  input  logic [lms_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [lms_pkg::MS_W-1:0] out_span,
  output logic                     out_drop,
  output lms_pkg::status_t         status
);
  import lms_pkg::*;

  localparam int AW  = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int MIW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int MW  = $clog2(MAX_MACHINES + 1);
  localparam int LW  = JOB_W + AW;
  localparam int SW  = (LW > MS_W) ? LW : MS_W;

  logic [JOB_W-1:0] job_mem [MAX_JOBS];
  logic [JOB_W-1:0] job_rdata;
  logic [LW-1:0]    load_mem [MAX_MACHINES];
  logic [LW-1:0]    load_rdata;

  logic [CW-1:0]    count;
  logic             overflow;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [MW-1:0]    k;
  logic [JOB_W-1:0] v;
  logic [MIW-1:0]   best;
  logic [LW-1:0]    best_load;
  logic [LW-1:0]    span;
  logic [CFG_W-1:0] machines;

  logic [MW-1:0]    m_eff;
  logic [6:0]       cfg_ext;
  logic [CW-1:0]    jm1;
  logic [SW-1:0]    span_ext;
  logic [MS_W-1:0]  span_sat;
  logic             store_ok;

  // Machine count: zero means one, above the build limit saturates.
  always_comb begin
    cfg_ext = {3'b000, machines};
    if (cfg_ext == 7'd0) begin
      m_eff = MW'(1);
    end else if (cfg_ext > 7'(MAX_MACHINES)) begin
      m_eff = MW'(MAX_MACHINES);
    end else begin
      m_eff = MW'(cfg_ext);
    end
  end

  assign jm1      = j - CW'(1);
  assign store_ok = count < CW'(MAX_JOBS);
  assign span_ext = SW'(span);
  assign span_sat = (span_ext > SW'(MS_MAX)) ? MS_MAX : span_ext[MS_W-1:0];

  assign status.i_ge_n   = i >= count;
  assign status.j_zero   = j == '0;
  assign status.sort_lt  = job_rdata < v;
  assign status.k_eq_m   = k == m_eff;
  assign status.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      machines <= CFG_RST_VAL;
    end else if (cfg_wr_en) begin
      machines <= cfg_wr_data;
    end
  end

  // Job store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (op == OP_STORE && store_ok) begin
      job_mem[count[AW-1:0]] <= job_in;
    end else if (op == OP_SORT_FIN) begin
      job_mem[j[AW-1:0]] <= v;
    end else if (op == OP_SORT_SHIFT) begin
      job_mem[j[AW-1:0]] <= job_rdata;
    end
    if (op == OP_SORT_RDI || op == OP_A_RDJOB) begin
      job_rdata <= job_mem[i[AW-1:0]];
    end else if (op == OP_SORT_RDJ) begin
      job_rdata <= job_mem[jm1[AW-1:0]];
    end
  end

  // Machine loads: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (op == OP_CLR_STEP) begin
      load_mem[k[MIW-1:0]] <= '0;
    end else if (op == OP_A_ADD) begin
      load_mem[best] <= best_load + LW'(v);
    end
    if (op == OP_A_RDL || op == OP_M_RDL) begin
      load_rdata <= load_mem[k[MIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (op == OP_OUT) | (out_valid & ~out_ready);
      unique case (op)
        OP_STORE: begin
          if (store_ok) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        OP_OUT: begin
          count     <= '0;
          overflow  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_STORE: begin
        i <= CW'(1);
      end
      OP_SORT_LDV: begin
        v <= job_rdata;
        j <= i;
      end
      OP_SORT_SHIFT: begin
        j <= jm1;
      end
      OP_SORT_FIN: begin
        i <= i + CW'(1);
      end
      OP_CLR_START: begin
        k <= '0;
        i <= '0;
      end
      OP_CLR_STEP: begin
        k <= k + MW'(1);
      end
      OP_A_LDV: begin
        v         <= job_rdata;
        k         <= '0;
        best      <= '0;
        best_load <= '1;
      end
      OP_A_CMP: begin
        if (load_rdata < best_load) begin
          best      <= k[MIW-1:0];
          best_load <= load_rdata;
        end
        k <= k + MW'(1);
      end
      OP_A_ADD: begin
        i <= i + CW'(1);
      end
      OP_M_START: begin
        k    <= '0;
        span <= '0;
      end
      OP_M_CMP: begin
        if (load_rdata > span) begin
          span <= load_rdata;
        end
        k <= k + MW'(1);
      end
      OP_OUT: begin
        out_span <= span_sat;
        out_drop <= overflow;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/lms_ctrl.sv
// Controller of the LPT makespan scheduler: sequences job loading, the
// insertion sort, load clearing, assignment and the makespan scan. Uses lms_pkg.
module lms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  lms_pkg::status_t status,
  output lms_pkg::op_t     op
);
  import lms_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SORT_I   = 4'd1;
  localparam logic [3:0] S_SORT_V   = 4'd2;
  localparam logic [3:0] S_SORT_RD  = 4'd3;
  localparam logic [3:0] S_SORT_CMP = 4'd4;
  localparam logic [3:0] S_CLR      = 4'd5;
  localparam logic [3:0] S_A_JOB    = 4'd6;
  localparam logic [3:0] S_A_JW     = 4'd7;
  localparam logic [3:0] S_A_RD     = 4'd8;
  localparam logic [3:0] S_A_CMP    = 4'd9;
  localparam logic [3:0] S_M_RD     = 4'd10;
  localparam logic [3:0] S_M_CMP    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_STORE;
          if (in_last) begin
            state_next = S_SORT_I;
          end
        end
      end
      S_SORT_I: begin
        if (status.i_ge_n) begin
          op         = OP_CLR_START;
          state_next = S_CLR;
        end else begin
          op         = OP_SORT_RDI;
          state_next = S_SORT_V;
        end
      end
      S_SORT_V: begin
        op         = OP_SORT_LDV;
        state_next = S_SORT_RD;
      end
      S_SORT_RD: begin
        if (status.j_zero) begin
          op         = OP_SORT_FIN;
          state_next = S_SORT_I;
        end else begin
          op         = OP_SORT_RDJ;
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (status.sort_lt) begin
          op         = OP_SORT_SHIFT;
          state_next = S_SORT_RD;
        end else begin
          op         = OP_SORT_FIN;
          state_next = S_SORT_I;
        end
      end
      S_CLR: begin
        if (status.k_eq_m) begin
          state_next = S_A_JOB;
        end else begin
          op = OP_CLR_STEP;
        end
      end
      S_A_JOB: begin
        if (status.i_ge_n) begin
          op         = OP_M_START;
          state_next = S_M_RD;
        end else begin
          op         = OP_A_RDJOB;
          state_next = S_A_JW;
        end
      end
      S_A_JW: begin
        op         = OP_A_LDV;
        state_next = S_A_RD;
      end
      S_A_RD: begin
        if (status.k_eq_m) begin
          op         = OP_A_ADD;
          state_next = S_A_JOB;
        end else begin
          op         = OP_A_RDL;
          state_next = S_A_CMP;
        end
      end
      S_A_CMP: begin
        op         = OP_A_CMP;
        state_next = S_A_RD;
      end
      S_M_RD: begin
        if (status.k_eq_m) begin
          state_next = S_DONE;
        end else begin
          op         = OP_M_RDL;
          state_next = S_M_CMP;
        end
      end
      S_M_CMP: begin
        op         = OP_M_CMP;
        state_next = S_M_RD;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lpt_makespan_scheduler.sv
// LPT makespan scheduler, top level.
// Instantiates lms_ctrl and lms_datapath; uses lms_pkg.
//
//   s_axis carries one job per transfer: tdata[15:0] is the job duration,
//   tlast marks the final job of a set. Jobs load one per cycle while idle.
//   After the last job the set is sorted longest first and each job is put
//   on the least-loaded machine. m_axis then carries one transfer per set:
//   tdata[21:0] is the makespan, tuser flags jobs dropped beyond the store.
//   cfg_wr_en/cfg_wr_data set the number of machines (0 acts as 1, values
//   above MAX_MACHINES saturate); write only while the block is idle.
// After the last job the block sorts the set, clears the machine loads, assigns
//   the jobs (one load read per compare), scans for the makespan and outputs it.
// s_axis_tready is low from the last job until the result enters the output
//   register. If m_axis is stalled, the block still takes the next set and
//   holds that set's result until the previous one is transferred.
// Reset clears the job count, drop flag and output valid and sets the machine
//   count to 8. The job store needs no clearing.
module lpt_makespan_scheduler #(
  parameter int MAX_JOBS     = 64,
  parameter int MAX_MACHINES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] job_duration
  input  logic                        s_axis_tlast,  // last_job
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lms_pkg::DATA_W-1:0]  m_axis_tdata,  // [21:0] makespan, [23:22] zero
  output logic                        m_axis_tuser,  // jobs_dropped
  input  logic                        cfg_wr_en,
  input  logic [lms_pkg::CFG_W-1:0]   cfg_wr_data    // machines_in_use
);
  import lms_pkg::*;

  op_t              op;
  status_t          status;
  logic [MS_W-1:0]  out_span;

  lms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .op       (op)
  );

  lms_datapath #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .job_in      (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_span    (out_span),
    .out_drop    (m_axis_tuser),
    .status      (status)
  );

  assign m_axis_tdata = {(DATA_W - MS_W)'(0), out_span};

endmodule
